>>> rtl/aoats_pkg.sv
`default_nettype none

package aoats_pkg;

  localparam int AoaW  = 11;
  localparam int FreqW = 11;
  localparam int RateW = 9;
  localparam int VolW  = 8;

  // Ramp tables are indexed by the offset into a band, which never exceeds 45.
  localparam int RampIdxW  = 6;
  localparam int RampDepth = 1 << RampIdxW;

  localparam logic [FreqW-1:0] FreqLow  = FreqW'(400);
  localparam logic [FreqW-1:0] FreqMid  = FreqW'(900);
  localparam logic [FreqW-1:0] FreqHigh = FreqW'(1600);

  localparam logic [VolW-1:0]  VolumeFloor = VolW'(77);
  localparam logic [RateW-1:0] FixedRate   = RateW'(320);
  localparam int               RateBase    = 24;

  // Band limits in tenths of a degree.
  localparam logic signed [AoaW-1:0] LndLowLo  = 11'sd150;
  localparam logic signed [AoaW-1:0] LndLowHi  = 11'sd187;
  localparam logic signed [AoaW-1:0] LndMidLo  = 11'sd181;
  localparam logic signed [AoaW-1:0] LndMidHi  = 11'sd203;
  localparam logic signed [AoaW-1:0] LndHighLo = 11'sd197;
  localparam logic signed [AoaW-1:0] LndHighHi = 11'sd223;
  localparam logic signed [AoaW-1:0] FltLowLo  = 11'sd210;
  localparam logic signed [AoaW-1:0] FltLowHi  = 11'sd235;
  localparam logic signed [AoaW-1:0] FltMidLo  = 11'sd230;
  localparam logic signed [AoaW-1:0] FltMidHi  = 11'sd250;
  localparam logic signed [AoaW-1:0] FltHighLo = 11'sd245;
  localparam logic signed [AoaW-1:0] FltHighHi = 11'sd290;
  localparam logic signed [AoaW-1:0] FltStall  = 11'sd250;

  // Ramp slopes: rate rises by Num/10 Hz across a band that spans Den/10
  // tenths of a degree.
  localparam int LndLowNum  = 67;
  localparam int LndLowDen  = 370;
  localparam int LndHighNum = 47;
  localparam int LndHighDen = 260;
  localparam int FltLowNum  = 45;
  localparam int FltLowDen  = 250;
  localparam int FltHighNum = 81;
  localparam int FltHighDen = 450;

  typedef enum logic [1:0] {
    RAMP_LND_LOW,
    RAMP_LND_HIGH,
    RAMP_FLT_LOW,
    RAMP_FLT_HIGH
  } ramp_sel_t;

  typedef logic [RateW-1:0] ramp_tab_t [0:RampDepth-1];

  typedef struct packed {
    logic             active;
    logic [FreqW-1:0] frequency_hz;
    logic             pulsed;
    logic [RateW-1:0] pulse_rate;
  } tone_t;

  typedef struct packed {
    logic             tone_present;
    logic [FreqW-1:0] frequency_hz;
    logic             pulsed;
    logic [RateW-1:0] pulse_rate;
    logic [VolW-1:0]  tone_volume;
  } result_t;

  // Floored ramp, 1/16 Hz units, evaluated when the table is elaborated.
  function automatic ramp_tab_t ramp_table(input ramp_sel_t sel);
    ramp_tab_t t;
    for (int i = 0; i < RampDepth; i++) begin
      case (sel)
        RAMP_LND_LOW:  t[i] = RateW'(RateBase + (i * LndLowNum * 16) / LndLowDen);
        RAMP_LND_HIGH: t[i] = RateW'(RateBase + (i * LndHighNum * 16) / LndHighDen);
        RAMP_FLT_LOW:  t[i] = RateW'(RateBase + (i * FltLowNum * 16) / FltLowDen);
        RAMP_FLT_HIGH: t[i] = RateW'(RateBase + (i * FltHighNum * 16) / FltHighDen);
        default:       t[i] = '0;
      endcase
    end
    return t;
  endfunction

endpackage

`default_nettype wire

>>> rtl/aoa_aural_tone_selector.sv
`default_nettype none
// A request is registered in the input stage on acceptance; its first result is then
// registered in the output register, and a second result, if any, follows when it is free.
// Throughput: one result per cycle while m_axis_tready is high, so one request per cycle
// when it yields a single result, while a request with two tones holds the input stage for both.
// Reset: rst is synchronous and active high and empties the input and result stages.

module aoa_aural_tone_selector (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, lowest bit first: aoa_tenths[10:0], aoa_valid, secondary_power,
  // slats flag, gear flag, knob_volume[7:0], one zero pad bit.
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata, lowest bit first: frequency_hz[10:0], pulsed, pulse_rate[8:0],
  // tone_volume[7:0], three zero pad bits.
  output logic [31:0]      m_axis_tdata,
  // tuser: tone_present.
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  import aoats_pkg::*;

  localparam ramp_tab_t RampLndLow  = ramp_table(RAMP_LND_LOW);
  localparam ramp_tab_t RampLndHigh = ramp_table(RAMP_LND_HIGH);
  localparam ramp_tab_t RampFltLow  = ramp_table(RAMP_FLT_LOW);
  localparam ramp_tab_t RampFltHigh = ramp_table(RAMP_FLT_HIGH);

  // Input stage. A request stays here until its last result moves to the
  // output register; phase tells whether the second result is due next.
  logic                   in_full;
  logic                   phase;
  logic signed [AoaW-1:0] aoa;
  logic                   aoa_ok;
  logic                   power;
  logic                   slats;
  logic                   gear;
  logic [VolW-1:0]        knob;

  // Output stage.
  logic    out_valid;
  result_t out_res;
  logic    out_last;

  logic    out_free;
  logic    load;
  logic    consume;
  logic    last_of_item;
  logic    landing;
  logic    enabled;
  logic    stall;
  tone_t   tone_low;
  tone_t   tone_mid;
  tone_t   tone_band;
  tone_t   tone_top;
  tone_t   first_tone;
  tone_t   second_tone;
  logic    two;
  logic [VolW-1:0] vol;
  result_t first_res;
  result_t second_res;

  logic signed [AoaW-1:0] low_lo, low_hi, mid_lo, mid_hi, high_lo, high_hi;
  logic signed [AoaW-1:0] low_off, high_off;
  logic [RateW-1:0]       low_rate, high_rate;

  // Band selection for the landing or flight profile.
  always_comb begin
    landing = slats | gear;
    enabled = aoa_ok & power;
    if (landing) begin
      low_lo  = LndLowLo;  low_hi  = LndLowHi;
      mid_lo  = LndMidLo;  mid_hi  = LndMidHi;
      high_lo = LndHighLo; high_hi = LndHighHi;
    end else begin
      low_lo  = FltLowLo;  low_hi  = FltLowHi;
      mid_lo  = FltMidLo;  mid_hi  = FltMidHi;
      high_lo = FltHighLo; high_hi = FltHighHi;
    end
    low_off  = aoa - low_lo;
    high_off = aoa - high_lo;
    // The offsets give a valid ramp-table index only when the angle is inside the band.
    if (landing) begin
      low_rate  = RampLndLow[low_off[RampIdxW-1:0]];
      high_rate = RampLndHigh[high_off[RampIdxW-1:0]];
    end else begin
      low_rate  = RampFltLow[low_off[RampIdxW-1:0]];
      high_rate = RampFltHigh[high_off[RampIdxW-1:0]];
    end

    tone_low  = '{active: enabled && aoa >= low_lo && aoa <= low_hi,
                  frequency_hz: FreqLow, pulsed: 1'b1, pulse_rate: low_rate};
    tone_mid  = '{active: enabled && aoa >= mid_lo && aoa <= mid_hi,
                  frequency_hz: FreqMid, pulsed: 1'b0, pulse_rate: '0};
    tone_band = '{active: enabled && aoa >= high_lo && aoa <= high_hi,
                  frequency_hz: FreqHigh, pulsed: 1'b1, pulse_rate: high_rate};
    tone_top  = '{active: enabled && aoa > high_hi,
                  frequency_hz: FreqHigh, pulsed: 1'b1, pulse_rate: FixedRate};

    // Bands overlap only with their neighbor, so at most two tones are active
    // and the second one always follows the first in frequency order.
    first_tone  = '0;
    second_tone = '0;
    two         = 1'b0;
    if (tone_low.active) begin
      first_tone = tone_low;
      if (tone_mid.active) begin
        second_tone = tone_mid;
        two         = 1'b1;
      end
    end else if (tone_mid.active) begin
      first_tone = tone_mid;
      if (tone_band.active) begin
        second_tone = tone_band;
        two         = 1'b1;
      end
    end else if (tone_band.active) begin
      first_tone = tone_band;
    end else if (tone_top.active) begin
      first_tone = tone_top;
    end

    // The stall floor lifts a low knob setting in the flight profile at or above the stall angle.
    stall = !landing && aoa >= FltStall;
    vol   = (stall && knob < VolumeFloor) ? VolumeFloor : knob;

    // A request with no active tone gives one all-zero result.
    first_res  = '{tone_present: first_tone.active,
                   frequency_hz: first_tone.frequency_hz,
                   pulsed:       first_tone.pulsed,
                   pulse_rate:   first_tone.pulse_rate,
                   tone_volume:  first_tone.active ? vol : '0};
    second_res = '{tone_present: 1'b1,
                   frequency_hz: second_tone.frequency_hz,
                   pulsed:       second_tone.pulsed,
                   pulse_rate:   second_tone.pulse_rate,
                   tone_volume:  vol};
  end

  // Handshake between the stages. The output register takes a new result when
  // it is empty or its current result is being taken in the same cycle.
  always_comb begin
    out_free      = !out_valid || m_axis_tready;
    load          = in_full && out_free;
    last_of_item  = !two || phase;
    consume       = load && last_of_item;
    s_axis_tready = !in_full || consume;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_full <= 1'b1;
      end else if (consume) begin
        in_full <= 1'b0;
      end
      if (load) begin
        phase <= !last_of_item;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      aoa    <= s_axis_tdata[10:0];
      aoa_ok <= s_axis_tdata[11];
      power  <= s_axis_tdata[12];
      slats  <= s_axis_tdata[13];
      gear   <= s_axis_tdata[14];
      knob   <= s_axis_tdata[22:15];
    end
    if (load) begin
      out_res  <= phase ? second_res : first_res;
      out_last <= last_of_item;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.tone_present;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {3'b000, out_res.tone_volume, out_res.pulse_rate,
                          out_res.pulsed, out_res.frequency_hz};

  // The second result of a request is only ever pending for a held request.
  a_phase_held: assert property (@(posedge clk) disable iff (rst)
    phase |-> in_full)
    else $error("second result pending without a held request");

  // A first result that is not the last one is followed by the second result.
  a_second_next: assert property (@(posedge clk) disable iff (rst)
    (load && !last_of_item) |=> (phase && in_full))
    else $error("second result of a request was dropped");

  // A no-tone result is always the only result of its request.
  a_silent_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("no-tone result is not a lone all-zero result");

  // A steady tone carries no pulse rate.
  a_steady_rate: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser && !out_res.pulsed) |-> (out_res.pulse_rate == '0))
    else $error("steady tone with a nonzero pulse rate");

endmodule

`default_nettype wire
